// ===== rtl/core/text_terminal_output_renderer_defines.svh =====
// Assertion macros shared by the renderer RTL.
`ifndef TEXT_TERMINAL_OUTPUT_RENDERER_DEFINES_SVH
`define TEXT_TERMINAL_OUTPUT_RENDERER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TTOR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("renderer check failed");
`define TTOR_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("renderer forbidden condition");
`else
`define TTOR_ASSERT(lbl, clk, rst_n, prop)
`define TTOR_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/ttor_pkg.sv =====
// Shared constants and types of the text terminal renderer.
`default_nettype none
package ttor_pkg;
  localparam int ESC_BUF_LEN = 9;
  localparam int MAX_COLS    = 255;
  localparam int MAX_ROWS    = 127;
  localparam int RES_LIMIT   = 10;

  typedef logic [7:0] char_t;

  localparam char_t CH_BS    = 8'h08;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0a;
  localparam char_t CH_CR    = 8'h0d;
  localparam char_t CH_FF    = 8'h0c;
  localparam char_t CH_ESC   = 8'h1b;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2b;
  localparam char_t CH_MINUS = 8'h2d;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_SEMI  = 8'h3b;
  localparam char_t CH_A     = 8'h41;
  localparam char_t CH_B     = 8'h42;
  localparam char_t CH_C     = 8'h43;
  localparam char_t CH_D     = 8'h44;
  localparam char_t CH_H     = 8'h48;
  localparam char_t CH_J     = 8'h4a;
  localparam char_t CH_UC_Z  = 8'h5a;
  localparam char_t CH_LC_A  = 8'h61;
  localparam char_t CH_LC_M  = 8'h6d;
  localparam char_t CH_LC_Z  = 8'h7a;
  localparam char_t CH_TILDE = 8'h7e;
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CASE_OFS = 8'h20;

  localparam logic [1:0] OP_CELL   = 2'd0;
  localparam logic [1:0] OP_SCROLL = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_CURSOR = 2'd3;

  localparam logic [2:0] REG_SCREEN_COLS = 3'd0;
  localparam logic [2:0] REG_SCREEN_ROWS = 3'd1;
  localparam logic [2:0] REG_PP_ENABLE   = 3'd2;
  localparam logic [2:0] REG_NL_TO_CRNL  = 3'd3;
  localparam logic [2:0] REG_CR_TO_NL    = 3'd4;
  localparam logic [2:0] REG_DROP_CR     = 3'd5;
  localparam logic [2:0] REG_TO_UPPER    = 3'd6;

  typedef struct packed {
    char_t seq0;
    char_t seq1;
    logic  two;
    logic  drop_cand;
  } item_t;

  typedef struct packed {
    logic [7:0]  cols;
    logic [6:0]  rows;
    logic [14:0] size;
  } dims_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] row;
    logic [7:0] col;
    char_t      glyph;
  } res_t;
endpackage
`default_nettype wire

// ===== rtl/core/text_terminal_output_renderer.sv =====
// Top level of the text terminal renderer: front end, queue and render engine.
// One byte in gives a run of result words ending in a cursor-update word, unless it
// is a CR that the drop-CR option discards; every word of the run carries the final
// cursor index. In the render engine a byte leaves the queue, the cursor index is split
// into row and column (one quotient bit a cycle), the action runs, the index is rebuilt
// after LF, CR or a cursor command, each tab space is written, escape characters are
// scanned by A, B, C, D and H (H scans up to the separator, then the row, then the
// column), each scroll is issued and the cursor settles, the cursor-update word is
// appended, and then each result word leaves the result buffer, waiting while the
// output stalls. A newline expanded to CR plus LF runs the divide and the action twice.
// A two-word queue lets the front end take further bytes while the engine is busy.
`default_nettype none
module text_terminal_output_renderer #(
  parameter int ESC_BUF_LEN = ttor_pkg::ESC_BUF_LEN,
  parameter int MAX_COLS    = ttor_pkg::MAX_COLS,
  parameter int MAX_ROWS    = ttor_pkg::MAX_ROWS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       op_kind_o,
  output logic [6:0]       cell_row_o,
  output logic [7:0]       cell_col_o,
  output logic [7:0]       glyph_o,
  output logic [14:0]      cursor_pos_o,
  output logic             last_of_run_o
);
  ttor_pkg::item_t push_item, pop_item;
  ttor_pkg::dims_t dims;
  logic            push, full, pop, q_valid;

  ttor_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .data_byte_i,
    .full_i(full), .push_o(push), .item_o(push_item), .dims_o(dims)
  );

  ttor_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .item_o(pop_item)
  );

  ttor_back #(.ESC_BUF_LEN(ESC_BUF_LEN)) u_back (
    .clk_i, .rst_ni, .dims_i(dims), .valid_i(q_valid), .item_i(pop_item),
    .pop_o(pop), .out_valid_o, .out_ready_i, .op_kind_o, .cell_row_o,
    .cell_col_o, .glyph_o, .cursor_pos_o, .last_of_run_o
  );
endmodule
`default_nettype wire

// ===== rtl/core/ttor_front.sv =====
// Front end: configuration registers, screen size and byte post-processing.
`default_nettype none
module ttor_front #(
  parameter int MAX_COLS = ttor_pkg::MAX_COLS,
  parameter int MAX_ROWS = ttor_pkg::MAX_ROWS
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_idx_i,
  input  wire logic [7:0]      cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output ttor_pkg::item_t      item_o,
  output ttor_pkg::dims_t      dims_o
);
  logic [7:0]  cols_q;
  logic [6:0]  rows_q;
  logic        pp_q, nlcr_q, crnl_q, drop_q, upper_q;
  logic [7:0]  cols_eff;
  logic [6:0]  rows_eff;
  logic [14:0] size_q, size_d;
  logic [7:0]  b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= 8'd80;
      rows_q  <= 7'd25;
      pp_q    <= 1'b1;
      nlcr_q  <= 1'b1;
      crnl_q  <= 1'b0;
      drop_q  <= 1'b0;
      upper_q <= 1'b0;
      size_q  <= 15'd2000;
    end else begin
      size_q <= size_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ttor_pkg::REG_SCREEN_COLS: cols_q  <= cfg_data_i;
          ttor_pkg::REG_SCREEN_ROWS: rows_q  <= cfg_data_i[6:0];
          ttor_pkg::REG_PP_ENABLE:   pp_q    <= cfg_data_i[0];
          ttor_pkg::REG_NL_TO_CRNL:  nlcr_q  <= cfg_data_i[0];
          ttor_pkg::REG_CR_TO_NL:    crnl_q  <= cfg_data_i[0];
          ttor_pkg::REG_DROP_CR:     drop_q  <= cfg_data_i[0];
          ttor_pkg::REG_TO_UPPER:    upper_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (cols_q == 8'd0) cols_eff = 8'd1;
    else if (int'(cols_q) > MAX_COLS) cols_eff = 8'(MAX_COLS);
    else cols_eff = cols_q;
    if (rows_q == 7'd0) rows_eff = 7'd1;
    else if (int'(rows_q) > MAX_ROWS) rows_eff = 7'(MAX_ROWS);
    else rows_eff = rows_q;
    size_d = {7'b0, cols_eff} * {8'b0, rows_eff};
  end

  assign dims_o = '{cols: cols_eff, rows: rows_eff, size: size_q};

  always_comb begin
    b = data_byte_i;
    item_o.seq0      = data_byte_i;
    item_o.seq1      = ttor_pkg::CH_LF;
    item_o.two       = 1'b0;
    item_o.drop_cand = 1'b0;
    if (pp_q) begin
      if (upper_q && b >= ttor_pkg::CH_LC_A && b <= ttor_pkg::CH_LC_Z) begin
        b = b - ttor_pkg::CASE_OFS;
      end
      item_o.seq0 = b;
      if (b == ttor_pkg::CH_LF) begin
        if (nlcr_q) begin
          item_o.seq0 = ttor_pkg::CH_CR;
          item_o.two  = 1'b1;
        end
      end else if (b == ttor_pkg::CH_CR) begin
        if (crnl_q) item_o.seq0 = ttor_pkg::CH_LF;
        else item_o.drop_cand = drop_q;
      end
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
endmodule
`default_nettype wire

// ===== rtl/core/ttor_fifo.sv =====
// Two-word queue between the front end and the render engine.
`default_nettype none
`include "text_terminal_output_renderer_defines.svh"
module ttor_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ttor_pkg::item_t  item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output ttor_pkg::item_t       item_o
);
  ttor_pkg::item_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];

  `TTOR_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)
  `TTOR_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && !valid_o)
endmodule
`default_nettype wire

// ===== rtl/core/ttor_back.sv =====
// Render engine: cursor divide, character actions, escape parsing, result buffer.
`default_nettype none
`include "text_terminal_output_renderer_defines.svh"
module ttor_back #(
  parameter int ESC_BUF_LEN = ttor_pkg::ESC_BUF_LEN
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ttor_pkg::dims_t dims_i,
  input  wire logic            valid_i,
  input  wire ttor_pkg::item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           op_kind_o,
  output logic [6:0]           cell_row_o,
  output logic [7:0]           cell_col_o,
  output logic [7:0]           glyph_o,
  output logic [14:0]          cursor_pos_o,
  output logic                 last_of_run_o
);
  localparam int CNT_W = $clog2(ESC_BUF_LEN + 1);
  localparam int IDX_W = $clog2(ESC_BUF_LEN);
  localparam int RES_LIMIT = ttor_pkg::RES_LIMIT;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DIV    = 9'b000000010,
    S_EXEC   = 9'b000000100,
    S_PARSE  = 9'b000001000,
    S_TAB    = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_SCROLL = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    PH_SEMI = 3'b001,
    PH_WS   = 3'b010,
    PH_DIG  = 3'b100
  } phase_e;

  state_e          state_q, state_d;
  phase_e          ph_q, ph_d;
  ttor_pkg::item_t item_q, item_d;
  logic            idx_q, idx_d;
  logic [14:0]     cur_q, cur_d, np_q, np_d;
  logic [6:0]      row_q, row_d, mrow_q, mrow_d;
  logic [7:0]      col_q, col_d, mcol_q, mcol_d;
  logic [14:0]     dvd_q, dvd_d, quo_q, quo_d;
  logic [7:0]      rem_q, rem_d;
  logic [3:0]      dcnt_q, dcnt_d;
  logic [3:0]      tk_q, tk_d, tsp_q, tsp_d;
  logic [7:0]      prow_q, prow_d, pcol_q, pcol_d;
  logic            esc_act_q, esc_act_d;
  logic [CNT_W-1:0] esc_cnt_q, esc_cnt_d;
  logic [7:0]      esc_buf_q [ESC_BUF_LEN];
  logic            ebuf_we;
  ttor_pkg::char_t cmd_q, cmd_d;
  logic [CNT_W-1:0] ptr_q, ptr_d, semi_q, semi_d;
  logic [7:0]      val_q, val_d, rowv_q, rowv_d;
  logic            second_q, second_d;
  ttor_pkg::res_t  res_q [RES_LIMIT];
  logic [3:0]      n_q, n_d, rd_q, rd_d, nf;
  logic            wr_en;
  logic [3:0]      wr_idx;
  ttor_pkg::res_t  wr_res;
  logic            e_en;
  ttor_pkg::res_t  e_res;
  logic            ov_q, ov_d, last_q, last_d;
  ttor_pkg::res_t  o_q, o_d;
  logic [14:0]     pos_q, pos_d;

  ttor_pkg::char_t c, ch;
  logic [8:0]      t9, s9;
  logic            qbit, in_rng, pdone, is_ws, is_dig;
  logic [7:0]      pv, hr, hc;
  logic [11:0]     acc;
  logic [14:0]     clamp_cur;

  assign c = idx_q ? item_q.seq1 : item_q.seq0;

  always_comb begin
    state_d = state_q;  ph_d = ph_q;  item_d = item_q;  idx_d = idx_q;
    cur_d = cur_q;  np_d = np_q;  row_d = row_q;  col_d = col_q;
    mrow_d = mrow_q;  mcol_d = mcol_q;  dvd_d = dvd_q;  quo_d = quo_q;
    rem_d = rem_q;  dcnt_d = dcnt_q;  tk_d = tk_q;  tsp_d = tsp_q;
    prow_d = prow_q;  pcol_d = pcol_q;  esc_act_d = esc_act_q;
    esc_cnt_d = esc_cnt_q;  ebuf_we = 1'b0;  cmd_d = cmd_q;  ptr_d = ptr_q;
    semi_d = semi_q;  val_d = val_q;  rowv_d = rowv_q;  second_d = second_q;
    n_d = n_q;  rd_d = rd_q;  wr_en = 1'b0;  wr_idx = n_q;  wr_res = '0;
    e_en = 1'b0;  e_res = '0;  ov_d = ov_q && !out_ready_i;  last_d = last_q;
    o_d = o_q;  pos_d = pos_q;  pop_o = 1'b0;
    t9 = '0;  s9 = '0;  qbit = 1'b0;  pdone = 1'b0;  pv = val_q;
    hr = '0;  hc = '0;  acc = '0;  nf = n_q;
    clamp_cur = (cur_q >= dims_i.size) ? dims_i.size - 15'd1 : cur_q;
    in_rng = ptr_q < esc_cnt_q;
    ch = in_rng ? esc_buf_q[ptr_q[IDX_W-1:0]] : ttor_pkg::CH_NUL;
    is_ws = ch == ttor_pkg::CH_SPACE || (ch >= ttor_pkg::CH_TAB && ch <= ttor_pkg::CH_CR);
    is_dig = ch >= ttor_pkg::CH_ZERO && ch <= ttor_pkg::CH_NINE;

    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          item_d = item_i;
          idx_d = 1'b0;
          n_d = 4'd0;
          cur_d = clamp_cur;
          dvd_d = clamp_cur;
          quo_d = '0;
          rem_d = '0;
          dcnt_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle: row = cursor / cols, col = remainder
        t9 = {rem_q, dvd_q[14]};
        if (t9 >= {1'b0, dims_i.cols}) begin
          rem_d = 8'(t9 - {1'b0, dims_i.cols});
          qbit = 1'b1;
        end else begin
          rem_d = t9[7:0];
        end
        quo_d = {quo_q[13:0], qbit};
        dvd_d = {dvd_q[13:0], 1'b0};
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'd14) begin
          row_d = quo_d[6:0];
          col_d = rem_d;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        np_d = cur_q;
        state_d = S_SCROLL;
        if (!idx_q && item_q.drop_cand && col_q == 8'd0) begin
          state_d = S_IDLE;
        end else if (esc_act_q) begin
          if (c == ttor_pkg::CH_A || c == ttor_pkg::CH_B ||
              c == ttor_pkg::CH_C || c == ttor_pkg::CH_D) begin
            cmd_d = c;  ptr_d = CNT_W'(1);  ph_d = PH_WS;  val_d = '0;
            second_d = 1'b0;  state_d = S_PARSE;
          end else if (c == ttor_pkg::CH_H) begin
            cmd_d = c;  ptr_d = CNT_W'(1);  ph_d = PH_SEMI;  val_d = '0;
            second_d = 1'b0;  state_d = S_PARSE;
          end else if (c == ttor_pkg::CH_J) begin
            e_en = 1'b1;  e_res.kind = ttor_pkg::OP_CLEAR;
            esc_act_d = 1'b0;  esc_cnt_d = '0;
          end else if (c == ttor_pkg::CH_LC_M ||
                       (c >= ttor_pkg::CH_A && c <= ttor_pkg::CH_UC_Z) ||
                       (c >= ttor_pkg::CH_LC_A && c <= ttor_pkg::CH_LC_Z)) begin
            esc_act_d = 1'b0;  esc_cnt_d = '0;
          end else if (int'(esc_cnt_q) < ESC_BUF_LEN) begin
            ebuf_we = 1'b1;
            esc_cnt_d = esc_cnt_q + CNT_W'(1);
          end
        end else if (c == ttor_pkg::CH_LF) begin
          mrow_d = row_q + 7'd1;  mcol_d = col_q;  state_d = S_MUL;
        end else if (c == ttor_pkg::CH_CR) begin
          mrow_d = row_q;  mcol_d = 8'd0;  state_d = S_MUL;
        end else if (c == ttor_pkg::CH_BS) begin
          np_d = (cur_q == 15'd0) ? 15'd0 : cur_q - 15'd1;
        end else if (c == ttor_pkg::CH_TAB) begin
          tk_d = 4'd0;  tsp_d = 4'd8 - {1'b0, col_q[2:0]};
          prow_d = {1'b0, row_q};  pcol_d = col_q;  state_d = S_TAB;
        end else if (c == ttor_pkg::CH_FF) begin
          e_en = 1'b1;  e_res.kind = ttor_pkg::OP_CLEAR;
        end else if (c == ttor_pkg::CH_ESC) begin
          esc_act_d = 1'b1;  esc_cnt_d = '0;
        end else if (c >= ttor_pkg::CH_SPACE && c <= ttor_pkg::CH_TILDE) begin
          e_en = 1'b1;
          e_res = '{kind: ttor_pkg::OP_CELL, row: row_q, col: col_q, glyph: c};
          np_d = cur_q + 15'd1;
        end
      end
      S_PARSE: begin
        acc = {4'b0, val_q} * 12'd10 + {8'b0, ch[3:0]};
        case (ph_q)
          PH_SEMI: begin
            if (!in_rng || ch == ttor_pkg::CH_NUL) begin
              esc_act_d = 1'b0;  esc_cnt_d = '0;  np_d = cur_q;  state_d = S_SCROLL;
            end else if (ch == ttor_pkg::CH_SEMI) begin
              semi_d = ptr_q;  ptr_d = CNT_W'(1);  ph_d = PH_WS;  val_d = '0;
            end else begin
              ptr_d = ptr_q + CNT_W'(1);
            end
          end
          PH_WS: begin
            if (!in_rng) begin
              pdone = 1'b1;  pv = '0;
            end else if (is_ws) begin
              ptr_d = ptr_q + CNT_W'(1);
            end else if (is_dig) begin
              val_d = {4'b0, ch[3:0]};  ptr_d = ptr_q + CNT_W'(1);  ph_d = PH_DIG;
            end else begin
              pdone = 1'b1;  pv = '0;
            end
          end
          PH_DIG: begin
            if (in_rng && is_dig) begin
              val_d = (acc > 12'd255) ? 8'd255 : acc[7:0];
              ptr_d = ptr_q + CNT_W'(1);
            end else begin
              pdone = 1'b1;  pv = val_q;
            end
          end
          default: state_d = S_IDLE;
        endcase
        if (pdone) begin
          if (cmd_q == ttor_pkg::CH_H && !second_q) begin
            // row parsed; parse the column after the separator
            rowv_d = pv;  ptr_d = semi_q + CNT_W'(1);  second_d = 1'b1;
            ph_d = PH_WS;  val_d = '0;
          end else begin
            mrow_d = row_q;  mcol_d = col_q;
            if (cmd_q == ttor_pkg::CH_A) begin
              mrow_d = (pv > {1'b0, row_q}) ? 7'd0 : 7'({1'b0, row_q} - pv);
            end else if (cmd_q == ttor_pkg::CH_B) begin
              s9 = {2'b0, row_q} + {1'b0, pv};
              mrow_d = (s9 > {2'b0, dims_i.rows} - 9'd1) ? dims_i.rows - 7'd1 : s9[6:0];
            end else if (cmd_q == ttor_pkg::CH_C) begin
              s9 = {1'b0, col_q} + {1'b0, pv};
              mcol_d = (s9 > {1'b0, dims_i.cols} - 9'd1) ? dims_i.cols - 8'd1 : s9[7:0];
            end else if (cmd_q == ttor_pkg::CH_D) begin
              mcol_d = (pv > col_q) ? 8'd0 : col_q - pv;
            end else begin
              hr = (rowv_q == 8'd0) ? 8'd0 : rowv_q - 8'd1;
              hc = (pv == 8'd0) ? 8'd0 : pv - 8'd1;
              mrow_d = (hr > {1'b0, dims_i.rows} - 8'd1) ? dims_i.rows - 7'd1 : hr[6:0];
              mcol_d = (hc > dims_i.cols - 8'd1) ? dims_i.cols - 8'd1 : hc;
            end
            esc_act_d = 1'b0;  esc_cnt_d = '0;  state_d = S_MUL;
          end
        end
      end
      S_TAB: begin
        if (prow_q < {1'b0, dims_i.rows}) begin
          e_en = 1'b1;
          e_res = '{kind: ttor_pkg::OP_CELL, row: prow_q[6:0], col: pcol_q,
                    glyph: ttor_pkg::CH_SPACE};
        end
        if (pcol_q == dims_i.cols - 8'd1) begin
          pcol_d = 8'd0;  prow_d = prow_q + 8'd1;
        end else begin
          pcol_d = pcol_q + 8'd1;
        end
        tk_d = tk_q + 4'd1;
        if (tk_q == tsp_q - 4'd1) begin
          np_d = cur_q + {11'b0, tsp_q};
          state_d = S_SCROLL;
        end
      end
      S_MUL: begin
        np_d = {8'b0, mrow_q} * {7'b0, dims_i.cols} + {7'b0, mcol_q};
        state_d = S_SCROLL;
      end
      S_SCROLL: begin
        if (np_q >= dims_i.size) begin
          e_en = 1'b1;  e_res.kind = ttor_pkg::OP_SCROLL;
          np_d = np_q - {7'b0, dims_i.cols};
        end else begin
          cur_d = np_q;
          if (!idx_q && item_q.two) begin
            idx_d = 1'b1;  dvd_d = np_q;  quo_d = '0;  rem_d = '0;  dcnt_d = '0;
            state_d = S_DIV;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        nf = (n_q >= 4'(RES_LIMIT)) ? 4'(RES_LIMIT - 1) : n_q;
        wr_en = 1'b1;  wr_idx = nf;
        wr_res = '{kind: ttor_pkg::OP_CURSOR, row: 7'd0, col: 8'd0, glyph: 8'd0};
        n_d = nf + 4'd1;  rd_d = 4'd0;  state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;  o_d = res_q[rd_q];  pos_d = cur_q;
          last_d = rd_q == n_q - 4'd1;  rd_d = rd_q + 4'd1;
          if (rd_q == n_q - 4'd1) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // drop results past the buffer limit; the cursor word still gets a slot
    if (e_en && n_q < 4'(RES_LIMIT)) begin
      wr_en = 1'b1;  wr_idx = n_q;  wr_res = e_res;  n_d = n_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ph_q      <= PH_WS;
      idx_q     <= 1'b0;
      cur_q     <= '0;
      esc_act_q <= 1'b0;
      esc_cnt_q <= '0;
      n_q       <= '0;
      rd_q      <= '0;
      ov_q      <= 1'b0;
      second_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ph_q      <= ph_d;
      idx_q     <= idx_d;
      cur_q     <= cur_d;
      esc_act_q <= esc_act_d;
      esc_cnt_q <= esc_cnt_d;
      n_q       <= n_d;
      rd_q      <= rd_d;
      ov_q      <= ov_d;
      second_q  <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;  np_q <= np_d;  row_q <= row_d;  col_q <= col_d;
    mrow_q <= mrow_d;  mcol_q <= mcol_d;  dvd_q <= dvd_d;  quo_q <= quo_d;
    rem_q <= rem_d;  dcnt_q <= dcnt_d;  tk_q <= tk_d;  tsp_q <= tsp_d;
    prow_q <= prow_d;  pcol_q <= pcol_d;  cmd_q <= cmd_d;  ptr_q <= ptr_d;
    semi_q <= semi_d;  val_q <= val_d;  rowv_q <= rowv_d;
    last_q <= last_d;  o_q <= o_d;  pos_q <= pos_d;
    if (ebuf_we) esc_buf_q[esc_cnt_q[IDX_W-1:0]] <= c;
    if (wr_en) res_q[wr_idx] <= wr_res;
  end

  assign out_valid_o   = ov_q;
  assign op_kind_o     = o_q.kind;
  assign cell_row_o    = o_q.row;
  assign cell_col_o    = o_q.col;
  assign glyph_o       = o_q.glyph;
  assign cursor_pos_o  = pos_q;
  assign last_of_run_o = last_q;

  `TTOR_ASSERT(a_res_count, clk_i, rst_ni, n_q <= 4'(RES_LIMIT))
  `TTOR_ASSERT(a_last_cursor, clk_i, rst_ni, out_valid_o && last_of_run_o |-> op_kind_o == ttor_pkg::OP_CURSOR)
  `TTOR_ASSERT(a_esc_count, clk_i, rst_ni, int'(esc_cnt_q) <= ESC_BUF_LEN)
endmodule
`default_nettype wire
